FILE: rtl/sbusfd_pkg.sv
// ----------------------------------------------------------------------------
// sbusfd_pkg
// Shared constants and types for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbusfd_pkg;

	localparam int FRAME_BYTES      = 25;
	localparam int CHANNEL_BITS     = 11;
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int MAX_CHANNELS     = 16;

	localparam logic [7:0] HDR_BYTE = 8'h0F;
	localparam logic [7:0] FTR_BYTE = 8'h00;

	// Frame store holds bytes 0..23; the footer is never stored.
	localparam int STORE_DEPTH = FRAME_BYTES - 1;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int FLAGS_AT    = 23;
	localparam int DATA_FIRST  = 1;
	localparam int DATA_LAST   = 22;

	localparam int POS_W   = $clog2(FRAME_BYTES);
	localparam int CH_W    = $clog2(MAX_CHANNELS);
	localparam int BYTE_W  = 8;
	// Worst case: ten bits left over plus one fresh byte.
	localparam int BUF_W   = CHANNEL_BITS + BYTE_W - 1;
	localparam int CNT_W   = $clog2(BUF_W + 1);

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_COLLECT,
		ST_UNPACK
	} state_t;

	typedef struct packed {
		logic clear;
		logic fill;
		logic take;
	} bb_ctrl_t;

endpackage

FILE: rtl/sbusfd_if.sv
// ----------------------------------------------------------------------------
// sbusfd_if
// Valid/ready channels for received bytes and decoded channel results.
// ----------------------------------------------------------------------------
interface sbusfd_in_if
	import sbusfd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbusfd_out_if
	import sbusfd_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [CH_W-1:0]         channel_index;
	logic [CHANNEL_BITS-1:0] channel_value;
	logic [BYTE_W-1:0]       frame_flags;
	logic                    last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output frame_flags, output last_channel, input ready);
	modport sink   (input valid, input channel_index, input channel_value,
		input frame_flags, input last_channel, output ready);
endinterface

FILE: rtl/sbusfd_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS receive frame decoder: header hunt, 24-byte store, footer check and
// serial unpacking of the channel values.
// ----------------------------------------------------------------------------
// Usage
//   rx  : one received byte per beat. Ready is high while hunting for the
//         0x0F header and while collecting the frame; it drops while a good
//         frame is being unpacked.
//   res : one beat per channel, index 0 first, with the 11-bit value, the
//         frame's flags byte and a last marker on the final channel.
// Sequencing
//   After a zero footer the bit buffer is cleared, then stored bytes are read
//   and appended until a full value is held, and the first result is
//   registered. The bit buffer waits on registered RAM reads, so unpacking
//   pauses between some results until enough bits have arrived.
//   A frame whose footer is not zero is dropped with no result.
// Reset
//   Returns to header hunting with no result pending; the frame store is
//   not cleared, every entry is written before it is read.
// Stall
//   A stalled result holds in the output register and unpacking waits; once
//   the last channel sits in that register, rx is ready again.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
	import sbusfd_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sbusfd_in_if.sink    rx,
	sbusfd_out_if.source res
);

	state_t                  state_q, state_d;
	logic [POS_W-1:0]        pos_q;
	logic [STORE_AW-1:0]     rd_addr_q;
	logic                    rd_pend_q;
	logic [CH_W-1:0]         ch_q;
	logic [BYTE_W-1:0]       flags_q;

	logic                    out_valid_q;
	logic [CH_W-1:0]         out_index_q;
	logic [CHANNEL_BITS-1:0] out_value_q;
	logic [BYTE_W-1:0]       out_flags_q;
	logic                    out_last_q;

	logic                    rx_fire;
	logic                    is_hdr;
	logic                    at_footer;
	logic                    footer_ok;
	logic                    ram_we;
	logic                    ram_re;
	logic [BYTE_W-1:0]       ram_rd_data;
	logic                    slot_free;
	logic                    last_ch;
	bb_ctrl_t                bb_ctrl;
	logic [CHANNEL_BITS-1:0] bb_value;
	logic [CNT_W-1:0]        bb_nbits;
	logic [CNT_W-1:0]        bb_nbits_next;

	assign rx_fire   = rx.valid && rx.ready;
	assign is_hdr    = (rx.rx_byte == HDR_BYTE);
	assign at_footer = (pos_q >= POS_W'(FRAME_BYTES - 1));
	assign footer_ok = (rx.rx_byte == FTR_BYTE);
	assign slot_free = !out_valid_q || res.ready;
	assign last_ch   = (ch_q == CH_W'(NUM_CHANNELS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (rx_fire && is_hdr) begin
					state_d = ST_COLLECT;
				end
			end
			ST_COLLECT: begin
				if (rx_fire && at_footer) begin
					state_d = footer_ok ? ST_UNPACK : ST_HUNT;
				end
			end
			ST_UNPACK: begin
				if (bb_ctrl.take && last_ch) begin
					state_d = ST_HUNT;
				end
			end
			default: state_d = ST_HUNT;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rx.ready      = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		bb_ctrl.clear = 1'b0;
		bb_ctrl.fill  = 1'b0;
		bb_ctrl.take  = 1'b0;
		unique case (state_q)
			ST_HUNT: begin
				rx.ready = 1'b1;
				ram_we   = rx_fire && is_hdr;
			end
			ST_COLLECT: begin
				rx.ready      = 1'b1;
				ram_we        = rx_fire && !at_footer;
				bb_ctrl.clear = rx_fire && at_footer && footer_ok;
			end
			ST_UNPACK: begin
				bb_ctrl.fill = rd_pend_q;
				bb_ctrl.take = (bb_nbits >= CNT_W'(CHANNEL_BITS)) && slot_free;
				// fetch ahead while the buffer will still be short of a value
				ram_re = (bb_nbits_next < CNT_W'(CHANNEL_BITS))
					&& (rd_addr_q <= STORE_AW'(DATA_LAST));
			end
			default: begin
				rx.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			pos_q     <= '0;
			rd_addr_q <= '0;
			rd_pend_q <= 1'b0;
			ch_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_HUNT && rx_fire && is_hdr) begin
				pos_q <= POS_W'(1);
			end else if (state_q == ST_COLLECT && rx_fire) begin
				pos_q <= at_footer ? '0 : pos_q + POS_W'(1);
			end
			if (bb_ctrl.clear) begin
				rd_addr_q <= STORE_AW'(DATA_FIRST);
				rd_pend_q <= 1'b0;
				ch_q      <= '0;
			end else if (state_q == ST_UNPACK) begin
				rd_pend_q <= ram_re;
				if (ram_re) begin
					rd_addr_q <= rd_addr_q + STORE_AW'(1);
				end
				if (bb_ctrl.take) begin
					ch_q <= ch_q + CH_W'(1);
				end
			end
		end
	end

	// hold the flags byte aside so every result of the frame can carry it
	always_ff @(posedge clk) begin
		if (state_q == ST_COLLECT && rx_fire && pos_q == POS_W'(FLAGS_AT)) begin
			flags_q <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (bb_ctrl.take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bb_ctrl.take) begin
			out_index_q <= ch_q;
			out_value_q <= bb_value;
			out_flags_q <= flags_q;
			out_last_q  <= last_ch;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.channel_index = out_index_q;
	assign res.channel_value = out_value_q;
	assign res.frame_flags   = out_flags_q;
	assign res.last_channel  = out_last_q;

	sbusfd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (pos_q[STORE_AW-1:0]),
		.wr_data (rx.rx_byte),
		.re      (ram_re),
		.rd_addr (rd_addr_q),
		.rd_data (ram_rd_data)
	);

	sbusfd_bitbuf u_bitbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (bb_ctrl),
		.fill_byte  (ram_rd_data),
		.value      (bb_value),
		.nbits      (bb_nbits),
		.nbits_next (bb_nbits_next)
	);

	a_res_from_unpack: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UNPACK))
		else $error("result raised outside unpacking");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last_channel)
		|-> (res.channel_index == CH_W'(NUM_CHANNELS - 1)))
		else $error("last marker on wrong channel");

	a_bad_footer_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COLLECT && rx_fire && at_footer && !footer_ok)
		|=> (state_q == ST_HUNT && !$rose(out_valid_q)))
		else $error("bad footer not dropped");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNPACK) |-> (bb_nbits <= CNT_W'(BUF_W)))
		else $error("bit buffer overrun");

endmodule

FILE: rtl/sbusfd_ram.sv
// ----------------------------------------------------------------------------
// sbusfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbusfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/sbusfd_bitbuf.sv
// ----------------------------------------------------------------------------
// sbusfd_bitbuf
// Shared LSB-first bit buffer: per step it can take one stored byte, hand
// out one 11-bit channel value, or both; a clear empties it.
// ----------------------------------------------------------------------------
module sbusfd_bitbuf
	import sbusfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  bb_ctrl_t                ctrl,
	input  logic [BYTE_W-1:0]       fill_byte,
	output logic [CHANNEL_BITS-1:0] value,
	output logic [CNT_W-1:0]        nbits,
	output logic [CNT_W-1:0]        nbits_next
);

	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] nbits_q;
	logic [BUF_W-1:0] shifted;
	logic [CNT_W-1:0] cnt_taken;
	logic [BUF_W-1:0] buf_d;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		shifted   = ctrl.take ? (buf_q >> CHANNEL_BITS) : buf_q;
		cnt_taken = ctrl.take ? (nbits_q - CNT_W'(CHANNEL_BITS)) : nbits_q;
		buf_d     = shifted;
		cnt_d     = cnt_taken;
		if (ctrl.fill) begin
			// append the new byte above the bits still held
			buf_d = shifted | (BUF_W'(fill_byte) << cnt_taken);
			cnt_d = cnt_taken + CNT_W'(BYTE_W);
		end
		if (ctrl.clear) begin
			buf_d = '0;
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbits_q <= '0;
		end else begin
			nbits_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
	end

	assign value      = buf_q[CHANNEL_BITS-1:0];
	assign nbits      = nbits_q;
	assign nbits_next = cnt_d;

endmodule

FILE: tb/tb_sbus_frame_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder
// Drives received bytes into the SBUS frame decoder with random gaps,
// stalls the result channel at random, and checks every channel result
// against a byte-level model of the header hunt, frame store and unpacking.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder;
	import sbusfd_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int DATA_BYTES   = DATA_LAST - DATA_FIRST + 1;
	localparam int RANDOM_BEATS = 170;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [CH_W-1:0]         index;
		logic [CHANNEL_BITS-1:0] value;
		logic [BYTE_W-1:0]       flags;
		logic                    last;
	} channel_result_t;

	typedef logic [BYTE_W-1:0] payload_t [DATA_FIRST:DATA_LAST];

	logic clk = 1'b0;
	logic arst_n;

	sbusfd_in_if  rx_ch ();
	sbusfd_out_if res_ch ();

	sbus_frame_decoder #(
		.NUM_CHANNELS(NCH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	always #5 clk = ~clk;

	// Decoder model state
	int                pos;
	logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
	channel_result_t   expected_channels [$];

	int    error_count;
	int    rx_beats;
	int    cycle_count;
	bit    rx_no_gaps;
	bit    res_no_stall;
	int    res_stall_left;

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Model one accepted byte; a good footer queues one result per channel.
	task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
		logic [8*DATA_BYTES-1:0] bits;
		channel_result_t         r;
		if (pos == 0) begin
			if (b == HDR_BYTE) begin
				frame_bytes[0] = b;
				pos = 1;
			end
		end else if (pos < FRAME_BYTES - 1) begin
			frame_bytes[pos] = b;
			pos++;
		end else begin
			pos = 0;
			if (b == FTR_BYTE) begin
				for (int i = DATA_FIRST; i <= DATA_LAST; i++)
					bits[8*(i-DATA_FIRST) +: 8] = frame_bytes[i];
				for (int c = 0; c < NCH; c++) begin
					r.index = c[CH_W-1:0];
					r.value = bits[c*CHANNEL_BITS +: CHANNEL_BITS];
					r.flags = frame_bytes[FLAGS_AT];
					r.last  = (c == NCH - 1);
					expected_channels.push_back(r);
				end
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (rx_no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		decode_rx_byte(b);
		rx_beats++;
	endtask

	task automatic send_frame(input payload_t data, input logic [BYTE_W-1:0] flags,
		input logic [BYTE_W-1:0] footer);
		send_rx_byte(HDR_BYTE);
		for (int i = DATA_FIRST; i <= DATA_LAST; i++)
			send_rx_byte(data[i]);
		send_rx_byte(flags);
		send_rx_byte(footer);
	endtask

	task automatic wait_results_drained();
		while (expected_channels.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result();
		channel_result_t e;
		if (expected_channels.size() == 0) begin
			report($sformatf("result ch %0d with nothing expected", res_ch.channel_index));
		end else begin
			e = expected_channels.pop_front();
			if (res_ch.channel_index !== e.index)
				report($sformatf("channel_index %0d, want %0d",
					res_ch.channel_index, e.index));
			if (res_ch.channel_value !== e.value)
				report($sformatf("ch %0d channel_value %0d, want %0d",
					e.index, res_ch.channel_value, e.value));
			if (res_ch.frame_flags !== e.flags)
				report($sformatf("ch %0d frame_flags %02h, want %02h",
					e.index, res_ch.frame_flags, e.flags));
			if (res_ch.last_channel !== e.last)
				report($sformatf("ch %0d last_channel %b, want %b",
					e.index, res_ch.last_channel, e.last));
		end
	endtask

	// Result sink: check each beat, then pick the next ready value.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				check_result();
			if ($urandom_range(0, 99) < 3)
				res_no_stall = ~res_no_stall;
			if (res_stall_left > 0) begin
				res_stall_left--;
				res_ch.ready <= 1'b0;
			end else if (res_no_stall) begin
				res_ch.ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:64]:  res_ch.ready <= 1'b1;
					[65:94]: res_ch.ready <= 1'b0;
					default: begin
						res_stall_left = $urandom_range(10, 40);
						res_ch.ready <= 1'b0;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sbus_frame_decoder: errors");
			$finish;
		end
	end

	// Bytes other than the header are dropped while hunting; 0x0E is one bit off.
	task automatic test_hunt_noise();
		send_rx_byte(8'h00);
		send_rx_byte(8'hFF);
		send_rx_byte(8'h0E);
	endtask

	// All ones, with a header byte inside the data that must not restart the frame.
	task automatic test_full_scale_frame();
		payload_t data;
		for (int i = DATA_FIRST; i <= DATA_LAST; i++)
			data[i] = 8'hFF;
		data[11] = HDR_BYTE;
		send_frame(data, 8'hFF, FTR_BYTE);
	endtask

	task automatic test_random_frames();
		payload_t          data;
		logic [BYTE_W-1:0] flags;
		logic [BYTE_W-1:0] footer;
		logic [BYTE_W-1:0] noise;
		int                kind;
		int                mode;
		int                frames;
		frames = 0;
		rx_beats = 0;
		while (rx_beats < RANDOM_BEATS) begin
			rx_no_gaps = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				// noise between frames; hold off the header so framing stays aligned
				repeat ($urandom_range(1, 4)) begin
					noise = BYTE_W'($urandom_range(0, 255));
					if (noise == HDR_BYTE)
						noise = 8'hF0;
					send_rx_byte(noise);
				end
			end else begin
				mode = $urandom_range(0, 9);
				for (int i = DATA_FIRST; i <= DATA_LAST; i++) begin
					case (mode)
						0:       data[i] = 8'h00;
						1:       data[i] = 8'hFF;
						2:       data[i] = (i % 2) ? 8'hAA : 8'h55;
						3:       data[i] = ($urandom_range(0, 3) == 0) ? HDR_BYTE
							: BYTE_W'($urandom_range(0, 255));
						default: data[i] = BYTE_W'($urandom_range(0, 255));
					endcase
				end
				case ($urandom_range(0, 5))
					0:       flags = 8'h00;
					1:       flags = 8'hFF;
					default: flags = BYTE_W'($urandom_range(0, 255));
				endcase
				footer = (kind < 27) ? BYTE_W'($urandom_range(1, 255)) : FTR_BYTE;
				send_frame(data, flags, footer);
				frames++;
				// let the result side empty completely once before carrying on
				if (frames == 3)
					wait_results_drained();
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		pos            = 0;
		error_count    = 0;
		rx_beats       = 0;
		cycle_count    = 0;
		rx_no_gaps     = 1'b0;
		res_no_stall   = 1'b0;
		res_stall_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hunt_noise();
		test_full_scale_frame();
		test_random_frames();

		rx_ch.valid <= 1'b0;
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_channels.size() != 0)
			report($sformatf("%0d channel results never arrived",
				expected_channels.size()));
		if (error_count == 0)
			$display("tb_sbus_frame_decoder: clean");
		else
			$display("tb_sbus_frame_decoder: errors");
		$finish;
	end

endmodule
